/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clock, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CCTS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ccts: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define CCTS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ccts: next-cycle check failed");

`endif

/* rtl/ccts_pkg.sv */
// ----------------------------------------------------------------------------
// ccts_pkg
// Types, widths, codes and reset values of the countdown trigger sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package ccts_pkg;

   localparam int ROWS       = 8;
   localparam int LEN_BITS   = 4;
   localparam int ROW_BITS   = $clog2(ROWS);
   localparam int POS_W      = LEN_BITS + 1;
   localparam int SPAN_W     = LEN_BITS + 1;
   localparam int PRESCALE_W = 3;
   localparam int NIBBLE     = 4;
   localparam int RULE_FIELD = 3;
   localparam int DEST_FIELD = 3;
   localparam int MASK_FIELD = 8;
   localparam int GATE_W     = 8;
   localparam int CMD_W      = 3;
   localparam int SEL_W      = 4;
   localparam int CSR_W      = 64;
   localparam int CSR_IDX_W  = 3;
   localparam int LFSR_W     = 16;
   localparam int CNT_W      = $clog2(LFSR_W);

   localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
   localparam logic [LFSR_W-1:0] LFSR_SEED = 16'h0001;

   localparam logic [LEN_BITS-1:0] LEN_RESET = LEN_BITS'(7);
   localparam logic [POS_W-1:0]    STOPPED   = '1;

   localparam logic [31:0] SPEED_RESET  = 32'd0;
   localparam logic [31:0] MIN_RESET    = 32'd2004318071;
   localparam logic [31:0] MAX_RESET    = 32'd2004318071;
   localparam logic [23:0] RULE_RESET   = 24'd2396745;
   localparam logic [23:0] DEST_RESET   = 24'd16434824;
   localparam logic [63:0] SYNC_RESET   = 64'd9241421688590303745;
   localparam logic [63:0] TRIG_RESET   = 64'd9241421688590303745;
   localparam logic [63:0] TOGGLE_RESET = 64'd0;

   typedef logic [LEN_BITS-1:0] len_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_RISE  = 3'd0,
      CMD_FALL  = 3'd1,
      CMD_RESET = 3'd2,
      CMD_STOP  = 3'd3,
      CMD_LOAD  = 3'd4
   } cmd_type;

   typedef enum logic [RULE_FIELD-1:0] {
      RULE_NONE = 3'd0,
      RULE_INC  = 3'd1,
      RULE_DEC  = 3'd2,
      RULE_MAX  = 3'd3,
      RULE_MIN  = 3'd4,
      RULE_RND  = 3'd5,
      RULE_POLE = 3'd6,
      RULE_STOP = 3'd7
   } rule_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SPEED  = 3'd0,
      CSR_MIN    = 3'd1,
      CSR_MAX    = 3'd2,
      CSR_RULE   = 3'd3,
      CSR_DEST   = 3'd4,
      CSR_SYNC   = 3'd5,
      CSR_TRIG   = 3'd6,
      CSR_TOGGLE = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic     start;
      rule_type rule;
      len_type  len;
      len_type  lo;
      len_type  hi;
   } rule_req_type;

   typedef struct packed {
      logic    busy;
      logic    done;
      logic    write_len;
      logic    stop_dest;
      len_type new_len;
   } rule_stat_type;

endpackage

`default_nettype wire

/* rtl/cascaded_countdown_trigger_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// cascaded_countdown_trigger_sequencer_unit
// Eight prescaled countdown rows that fire rules, resyncs and gate words.
// ----------------------------------------------------------------------------
// One request word carries a command: rising tick, falling tick, reset, stop
// or load. Every command gives exactly one response word holding the gate
// bits after it and the rows that fired (zero except on a rising tick). The
// unit takes one word at a time and holds req_stall while it works. A rising
// tick walks the rows one per cycle, pausing at each row that fires while its
// rule is applied and its sync, trigger and toggle masks take effect; for a
// random rule the remainder of the LFSR word over the span is taken one bit a
// cycle in the rule unit. A finished response waits in the output register,
// and the next request is taken while it waits. Configuration is written
// through csr_wr_en, csr_index and csr_wdata; the user must write it only
// while the unit is idle, and the unit itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cascaded_countdown_trigger_sequencer_unit
   import ccts_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,

   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [CMD_W-1:0]     req_cmd,
   input  wire logic [SEL_W-1:0]     req_row_sel,
   input  wire logic [3:0]           req_load_value,

   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [GATE_W-1:0]         rsp_gates,
   output logic [GATE_W-1:0]         rsp_fired,

   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_ROW,
      S_RULE_WAIT,
      S_FIRE,
      S_DONE
   } seq_state_type;

   // configuration registers
   logic [31:0] speed_words_ff;
   logic [31:0] min_words_ff;
   logic [31:0] max_words_ff;
   logic [23:0] rule_words_ff;
   logic [23:0] dest_words_ff;
   logic [63:0] sync_masks_ff;
   logic [63:0] trigger_masks_ff;
   logic [63:0] toggle_masks_ff;

   // row state
   len_type                cycle_len_ff [ROWS];
   logic [POS_W-1:0]       position_ff  [ROWS];
   logic [PRESCALE_W-1:0]  prescale_ff  [ROWS];
   logic [GATE_W-1:0]      gate_bits_ff;
   logic [GATE_W-1:0]      pulse_bits_ff;

   // sequencer
   seq_state_type          state_ff;
   logic [ROW_BITS-1:0]    row_ff;
   logic [ROW_BITS-1:0]    dest_ff;
   logic [GATE_W-1:0]      fired_ff;

   // output register
   logic                   rsp_valid_ff;
   logic [GATE_W-1:0]      rsp_gates_ff;
   logic [GATE_W-1:0]      rsp_fired_ff;

   rule_req_type           rule_req;
   rule_stat_type          rule_stat;

   logic [DEST_FIELD-1:0]  dest_raw;
   logic                   dest_ok;
   logic [ROW_BITS-1:0]    dest_idx;
   logic                   row_fires;
   logic                   row_last;
   logic [MASK_FIELD-1:0]  sync_row;
   logic [MASK_FIELD-1:0]  trig_row;
   logic [MASK_FIELD-1:0]  toggle_row;
   len_type                load_len;
   logic                   req_take;

   function automatic logic [PRESCALE_W-1:0] speed_of(input logic [ROW_BITS-1:0] r);
      return speed_words_ff[r*NIBBLE +: PRESCALE_W];
   endfunction

   function automatic len_type min_of(input logic [ROW_BITS-1:0] r);
      logic [NIBBLE-1:0] raw;
      raw = min_words_ff[r*NIBBLE +: NIBBLE];
      return len_type'(raw);
   endfunction

   function automatic len_type max_of(input logic [ROW_BITS-1:0] r);
      logic [NIBBLE-1:0] raw;
      raw = max_words_ff[r*NIBBLE +: NIBBLE];
      return len_type'(raw);
   endfunction

   // --------------------------------------------------------------------------
   // Configuration writes
   // --------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_words_ff   <= SPEED_RESET;
         min_words_ff     <= MIN_RESET;
         max_words_ff     <= MAX_RESET;
         rule_words_ff    <= RULE_RESET;
         dest_words_ff    <= DEST_RESET;
         sync_masks_ff    <= SYNC_RESET;
         trigger_masks_ff <= TRIG_RESET;
         toggle_masks_ff  <= TOGGLE_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_SPEED:  speed_words_ff   <= csr_wdata[31:0];
            CSR_MIN:    min_words_ff     <= csr_wdata[31:0];
            CSR_MAX:    max_words_ff     <= csr_wdata[31:0];
            CSR_RULE:   rule_words_ff    <= csr_wdata[23:0];
            CSR_DEST:   dest_words_ff    <= csr_wdata[23:0];
            CSR_SYNC:   sync_masks_ff    <= csr_wdata;
            CSR_TRIG:   trigger_masks_ff <= csr_wdata;
            CSR_TOGGLE: toggle_masks_ff  <= csr_wdata;
            default:    speed_words_ff   <= speed_words_ff;
         endcase
      end
   end

   // --------------------------------------------------------------------------
   // Current row decode
   // --------------------------------------------------------------------------
   assign dest_raw  = dest_words_ff[row_ff*DEST_FIELD +: DEST_FIELD];
   assign dest_ok   = (dest_raw < ROWS);
   assign dest_idx  = ROW_BITS'(dest_raw);
   assign row_fires = (prescale_ff[row_ff] == '0) && (position_ff[row_ff] == '0);
   assign row_last  = (row_ff == ROW_BITS'(ROWS - 1));
   assign sync_row  = sync_masks_ff[row_ff*MASK_FIELD +: MASK_FIELD];
   assign trig_row  = trigger_masks_ff[row_ff*MASK_FIELD +: MASK_FIELD];
   assign toggle_row = toggle_masks_ff[row_ff*MASK_FIELD +: MASK_FIELD];
   assign load_len  = len_type'(req_load_value);
   assign req_take  = req_valid && !req_stall;

   // Hand the firing row's rule, with its destination's length and bounds,
   // to the rule unit. An out-of-range destination turns the rule off.
   always_comb begin
      rule_req.start = (state_ff == S_ROW) && row_fires;
      rule_req.rule  = dest_ok ? rule_type'(rule_words_ff[row_ff*RULE_FIELD +: RULE_FIELD])
                               : RULE_NONE;
      rule_req.len   = cycle_len_ff[dest_idx];
      rule_req.lo    = min_of(dest_idx);
      rule_req.hi    = max_of(dest_idx);
   end

   ccts_rule_unit u_rule (
      .clock (clock),
      .reset (reset),
      .req   (rule_req),
      .stat  (rule_stat)
   );

   // --------------------------------------------------------------------------
   // Sequencer, row state and output register
   // --------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         row_ff        <= '0;
         fired_ff      <= '0;
         gate_bits_ff  <= '0;
         pulse_bits_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int n = 0; n < ROWS; n++) begin
            cycle_len_ff[n] <= LEN_RESET;
            position_ff[n]  <= {1'b0, LEN_RESET};
            prescale_ff[n]  <= '0;
         end
      end else begin
         // drop a response once it has been taken
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  fired_ff <= '0;
                  state_ff <= S_DONE;
                  unique case (cmd_type'(req_cmd))
                     CMD_RISE: begin
                        row_ff   <= '0;
                        state_ff <= S_ROW;
                     end
                     CMD_FALL: begin
                        gate_bits_ff  <= gate_bits_ff & ~pulse_bits_ff;
                        pulse_bits_ff <= '0;
                     end
                     CMD_RESET: begin
                        for (int n = 0; n < ROWS; n++) begin
                           if (req_row_sel == '0 || req_row_sel == SEL_W'(n + 1)) begin
                              position_ff[n] <= {1'b0, cycle_len_ff[n]};
                              prescale_ff[n] <= speed_of(ROW_BITS'(n));
                           end
                        end
                     end
                     CMD_STOP: begin
                        for (int n = 0; n < ROWS; n++) begin
                           if (req_row_sel == '0 || req_row_sel == SEL_W'(n + 1)) begin
                              position_ff[n] <= STOPPED;
                           end
                        end
                     end
                     CMD_LOAD: begin
                        if (req_row_sel < ROWS) begin
                           cycle_len_ff[req_row_sel[ROW_BITS-1:0]] <= load_len;
                           position_ff[req_row_sel[ROW_BITS-1:0]]  <= {1'b0, load_len};
                        end
                     end
                     default: fired_ff <= '0;
                  endcase
               end
            end

            S_ROW: begin
               if (prescale_ff[row_ff] != '0) begin
                  // hold the row back for another tick of its prescaler
                  prescale_ff[row_ff] <= prescale_ff[row_ff] - 1'b1;
                  if (row_last) state_ff <= S_DONE;
                  else          row_ff   <= row_ff + 1'b1;
               end else begin
                  prescale_ff[row_ff] <= speed_of(row_ff);
                  if (row_fires) begin
                     fired_ff[row_ff] <= 1'b1;
                     dest_ff          <= dest_idx;
                     state_ff         <= S_RULE_WAIT;
                  end else begin
                     // advance the countdown; a stopped row stays put
                     if (!position_ff[row_ff][POS_W-1]) begin
                        position_ff[row_ff] <= position_ff[row_ff] - 1'b1;
                     end
                     if (row_last) state_ff <= S_DONE;
                     else          row_ff   <= row_ff + 1'b1;
                  end
               end
            end

            S_RULE_WAIT: begin
               if (rule_stat.done) begin
                  if (rule_stat.write_len) cycle_len_ff[dest_ff] <= rule_stat.new_len;
                  if (rule_stat.stop_dest) position_ff[dest_ff]  <= STOPPED;
                  state_ff <= S_FIRE;
               end
            end

            S_FIRE: begin
               // the firing row stops unless its own sync bit restarts it
               position_ff[row_ff] <= STOPPED;
               for (int n = 0; n < ROWS; n++) begin
                  if (sync_row[n]) begin
                     position_ff[n] <= {1'b0, cycle_len_ff[n]};
                     prescale_ff[n] <= speed_of(ROW_BITS'(n));
                  end
                  if (trig_row[n]) begin
                     gate_bits_ff[n]  <= 1'b1;
                     pulse_bits_ff[n] <= 1'b1;
                  end else if (toggle_row[n]) begin
                     gate_bits_ff[n] <= ~gate_bits_ff[n];
                  end
               end
               if (row_last) begin
                  state_ff <= S_DONE;
               end else begin
                  row_ff   <= row_ff + 1'b1;
                  state_ff <= S_ROW;
               end
            end

            S_DONE: begin
               // load the response word once the output register is free
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_gates_ff <= gate_bits_ff;
                  rsp_fired_ff <= fired_ff;
                  state_ff     <= S_IDLE;
               end
            end

            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_gates = rsp_gates_ff;
   assign rsp_fired = rsp_fired_ff;

   // --------------------------------------------------------------------------
   // Checks
   // --------------------------------------------------------------------------
   `CCTS_ASSERT_NEXT(a_busy_after_take, req_take, req_stall)
   `CCTS_ASSERT_NEXT(a_rule_done_to_fire, state_ff == S_RULE_WAIT && rule_stat.done, state_ff == S_FIRE)
   `CCTS_ASSERT_NOW(a_unit_idle_outside_wait, state_ff != S_RULE_WAIT, !rule_stat.busy)

endmodule

`default_nettype wire

/* rtl/ccts_rule_unit.sv */
// ----------------------------------------------------------------------------
// ccts_rule_unit
// Applies one row rule to a destination length; random rule runs a
// bit-serial remainder of the advanced LFSR word over the span.
// ----------------------------------------------------------------------------
`default_nettype none

module ccts_rule_unit
   import ccts_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire rule_req_type  req,
   output rule_stat_type      stat
);

   typedef enum logic {U_IDLE, U_DIV} unit_state_type;

   unit_state_type      state_ff;
   logic [LFSR_W-1:0]   lfsr_ff;
   logic [LFSR_W-1:0]   dividend_ff;
   logic [SPAN_W-1:0]   rem_ff;
   logic [SPAN_W-1:0]   span_ff;
   len_type             lo_ff;
   logic [CNT_W-1:0]    count_ff;
   rule_stat_type       stat_ff;

   logic [LFSR_W-1:0]   lfsr_step;
   logic [SPAN_W-1:0]   span_calc;
   logic [SPAN_W:0]     trial;
   logic [SPAN_W-1:0]   rem_next;
   rule_stat_type       direct;
   len_type             dist_lo;
   len_type             dist_hi;

   assign lfsr_step = (lfsr_ff >> 1) ^ (lfsr_ff[0] ? LFSR_TAPS : '0);
   assign span_calc = (req.hi >= req.lo)
                    ? ({1'b0, req.hi} - {1'b0, req.lo} + SPAN_W'(1))
                    : SPAN_W'(1);

   // one restoring step: bring down the next dividend bit
   assign trial    = {rem_ff, dividend_ff[LFSR_W-1]};
   assign rem_next = (trial >= {1'b0, span_ff}) ? SPAN_W'(trial - {1'b0, span_ff})
                                                : SPAN_W'(trial);

   assign dist_lo = (req.len >= req.lo) ? len_type'(req.len - req.lo)
                                        : len_type'(req.lo - req.len);
   assign dist_hi = (req.len >= req.hi) ? len_type'(req.len - req.hi)
                                        : len_type'(req.hi - req.len);

   always_comb begin
      direct           = '0;
      direct.done      = 1'b1;
      direct.write_len = 1'b1;
      direct.new_len   = req.len;
      unique case (req.rule)
         RULE_INC:  direct.new_len = (req.len >= req.hi) ? req.lo
                                                         : len_type'(req.len + 1'b1);
         RULE_DEC:  direct.new_len = (req.len <= req.lo) ? req.hi
                                                         : len_type'(req.len - 1'b1);
         RULE_MAX:  direct.new_len = req.hi;
         RULE_MIN:  direct.new_len = req.lo;
         RULE_POLE: direct.new_len = (dist_lo < dist_hi) ? req.hi : req.lo;
         RULE_STOP: begin
            direct.write_len = 1'b0;
            direct.stop_dest = 1'b1;
         end
         RULE_RND:  direct.write_len = 1'b0;
         RULE_NONE: direct.write_len = 1'b0;
         default:   direct.write_len = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         lfsr_ff  <= LFSR_SEED;
         stat_ff  <= '0;
      end else begin
         stat_ff.done <= 1'b0;
         unique case (state_ff)
            U_IDLE: begin
               if (req.start) begin
                  if (req.rule == RULE_RND) begin
                     lfsr_ff     <= lfsr_step;
                     dividend_ff <= lfsr_step;
                     rem_ff      <= '0;
                     span_ff     <= span_calc;
                     lo_ff       <= req.lo;
                     count_ff    <= '0;
                     state_ff    <= U_DIV;
                  end else begin
                     stat_ff <= direct;
                  end
               end
            end
            U_DIV: begin
               dividend_ff <= dividend_ff << 1;
               rem_ff      <= rem_next;
               count_ff    <= count_ff + 1'b1;
               if (count_ff == CNT_W'(LFSR_W - 1)) begin
                  stat_ff.done      <= 1'b1;
                  stat_ff.write_len <= 1'b1;
                  stat_ff.stop_dest <= 1'b0;
                  stat_ff.new_len   <= len_type'({1'b0, lo_ff} + rem_next);
                  state_ff          <= U_IDLE;
               end
            end
            default: state_ff <= U_IDLE;
         endcase
      end
   end

   always_comb begin
      stat      = stat_ff;
      stat.busy = (state_ff == U_DIV);
   end

endmodule

`default_nettype wire

/* tb/ccts_gate_monitor.sv */
// ----------------------------------------------------------------------------
// ccts_gate_monitor
// Watches the request, response and register ports of the countdown trigger
// sequencer, predicts every response word and compares it field by field.
// ----------------------------------------------------------------------------
module ccts_gate_monitor
   import ccts_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [CMD_W-1:0]     req_cmd,
   input  logic [SEL_W-1:0]     req_row_sel,
   input  logic [3:0]           req_load_value,

   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [GATE_W-1:0]    rsp_gates,
   input  logic [GATE_W-1:0]    rsp_fired,

   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,

   output int                   mismatches,
   output int                   words_pending
);

   typedef struct packed {
      logic [GATE_W-1:0] gates;
      logic [GATE_W-1:0] fired;
   } gate_word_type;

   logic [CSR_W-1:0]      cfg_reg [8];
   len_type               cycle_len [ROWS];
   logic [POS_W-1:0]      position [ROWS];
   logic [PRESCALE_W-1:0] prescale [ROWS];
   logic [GATE_W-1:0]     gate_bits;
   logic [GATE_W-1:0]     pulse_bits;
   logic [LFSR_W-1:0]     rand_word;
   gate_word_type         gate_words_due [$];

   initial begin
      mismatches    = 0;
      words_pending = 0;
   end

   function automatic logic [PRESCALE_W-1:0] speed_of(int r);
      return cfg_reg[CSR_SPEED][NIBBLE*r +: PRESCALE_W];
   endfunction

   // Apply row r's rule to its destination row's length.
   task automatic retune_row(int r);
      rule_type rule;
      int       d, c, lo, hi, span, dl, dh;
      rule = rule_type'(cfg_reg[CSR_RULE][RULE_FIELD*r +: RULE_FIELD]);
      d    = int'(cfg_reg[CSR_DEST][DEST_FIELD*r +: DEST_FIELD]);
      if (d >= ROWS) return;
      c  = int'(cycle_len[d]);
      lo = int'(cfg_reg[CSR_MIN][NIBBLE*d +: LEN_BITS]);
      hi = int'(cfg_reg[CSR_MAX][NIBBLE*d +: LEN_BITS]);
      case (rule)
         RULE_INC: c = (c + 1 > hi) ? lo : c + 1;
         RULE_DEC: c = (c - 1 < lo) ? hi : c - 1;
         RULE_MAX: c = hi;
         RULE_MIN: c = lo;
         RULE_RND: begin
            rand_word = rand_word[0] ? ((rand_word >> 1) ^ LFSR_TAPS) : (rand_word >> 1);
            span = (hi >= lo) ? hi - lo + 1 : 1;
            c = lo + int'(rand_word) % span;
         end
         RULE_POLE: begin
            dl = (c > lo) ? c - lo : lo - c;
            dh = (c > hi) ? c - hi : hi - c;
            c  = (dl < dh) ? hi : lo;
         end
         RULE_STOP: begin
            position[d] = STOPPED;
            return;
         end
         default: return;
      endcase
      cycle_len[d] = len_type'(c);
   endtask

   // One rising tick: walk the rows in order, earlier rows seen by later ones.
   task automatic step_rows(output logic [GATE_W-1:0] fired);
      logic [MASK_FIELD-1:0] sm, tm, gm;
      fired = '0;
      for (int i = 0; i < ROWS; i++) begin
         if (prescale[i] != 0) begin
            prescale[i]--;
            continue;
         end
         prescale[i] = speed_of(i);
         if (position[i] == 0) begin
            sm = cfg_reg[CSR_SYNC][MASK_FIELD*i +: MASK_FIELD];
            tm = cfg_reg[CSR_TRIG][MASK_FIELD*i +: MASK_FIELD];
            gm = cfg_reg[CSR_TOGGLE][MASK_FIELD*i +: MASK_FIELD];
            fired[i] = 1'b1;
            retune_row(i);
            position[i] = STOPPED;
            for (int n = 0; n < ROWS; n++) begin
               if (sm[n]) begin
                  position[n] = POS_W'(cycle_len[n]);
                  prescale[n] = speed_of(n);
               end
               if (tm[n]) begin
                  gate_bits[n]  = 1'b1;
                  pulse_bits[n] = 1'b1;
               end else if (gm[n]) begin
                  gate_bits[n] = ~gate_bits[n];
               end
            end
         end else if (position[i] != STOPPED) begin
            position[i]--;
         end
      end
   endtask

   always @(posedge clock) begin
      gate_word_type    due;
      logic [GATE_W-1:0] fired_now;
      if (reset) begin
         cfg_reg[CSR_SPEED]  = CSR_W'(SPEED_RESET);
         cfg_reg[CSR_MIN]    = CSR_W'(MIN_RESET);
         cfg_reg[CSR_MAX]    = CSR_W'(MAX_RESET);
         cfg_reg[CSR_RULE]   = CSR_W'(RULE_RESET);
         cfg_reg[CSR_DEST]   = CSR_W'(DEST_RESET);
         cfg_reg[CSR_SYNC]   = SYNC_RESET;
         cfg_reg[CSR_TRIG]   = TRIG_RESET;
         cfg_reg[CSR_TOGGLE] = TOGGLE_RESET;
         for (int n = 0; n < ROWS; n++) begin
            cycle_len[n] = LEN_RESET;
            position[n]  = POS_W'(LEN_RESET);
            prescale[n]  = '0;
         end
         gate_bits  = '0;
         pulse_bits = '0;
         rand_word  = LFSR_SEED;
         gate_words_due.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_SPEED, CSR_MIN, CSR_MAX: cfg_reg[csr_index] = CSR_W'(csr_wdata[31:0]);
               CSR_RULE, CSR_DEST:          cfg_reg[csr_index] = CSR_W'(csr_wdata[23:0]);
               default:                     cfg_reg[csr_index] = csr_wdata;
            endcase
         end

         // Compare first: a word leaving now belongs to an earlier request.
         if (rsp_valid && !rsp_stall) begin
            if (gate_words_due.size() == 0) begin
               $error("unexpected response word: gates %02h fired %02h", rsp_gates, rsp_fired);
               mismatches++;
            end else begin
               due = gate_words_due.pop_front();
               if (rsp_gates !== due.gates) begin
                  $error("gates: expected %02h, actual %02h", due.gates, rsp_gates);
                  mismatches++;
               end
               if (rsp_fired !== due.fired) begin
                  $error("fired: expected %02h, actual %02h", due.fired, rsp_fired);
                  mismatches++;
               end
            end
         end

         if (req_valid && !req_stall) begin
            fired_now = '0;
            case (cmd_type'(req_cmd))
               CMD_RISE: step_rows(fired_now);
               CMD_FALL: begin
                  gate_bits  = gate_bits & ~pulse_bits;
                  pulse_bits = '0;
               end
               CMD_RESET, CMD_STOP: begin
                  for (int n = 0; n < ROWS; n++) begin
                     if (req_row_sel == 0 || req_row_sel == SEL_W'(n + 1)) begin
                        if (req_cmd == CMD_RESET) begin
                           position[n] = POS_W'(cycle_len[n]);
                           prescale[n] = speed_of(n);
                        end else begin
                           position[n] = STOPPED;
                        end
                     end
                  end
               end
               CMD_LOAD: begin
                  if (req_row_sel < ROWS) begin
                     cycle_len[req_row_sel[ROW_BITS-1:0]] = req_load_value[LEN_BITS-1:0];
                     position[req_row_sel[ROW_BITS-1:0]]  =
                        POS_W'(req_load_value[LEN_BITS-1:0]);
                  end
               end
               default: ;
            endcase
            due.gates = gate_bits;
            due.fired = fired_now;
            gate_words_due.push_back(due);
         end
      end
      words_pending = gate_words_due.size();
   end

endmodule

/* tb/cascaded_countdown_trigger_sequencer_unit_tb.sv */
// ----------------------------------------------------------------------------
// cascaded_countdown_trigger_sequencer_unit_tb
// Drives the countdown trigger sequencer with directed and random command
// words under varying idle and stall patterns and several register settings;
// a separate monitor predicts and checks every response word.
// ----------------------------------------------------------------------------
module cascaded_countdown_trigger_sequencer_unit_tb;
   import ccts_pkg::*;

   localparam int SEGMENTS          = 8;
   localparam int WORDS_PER_SEGMENT = 68;
   localparam int HOLD_CYCLES       = 300;
   // Slowest rising tick: every row fires with a random rule.
   localparam int SETTLE_CYCLES     = 200;

   // Command codes past load carry no name in the package: the block ignores them.
   localparam logic [CMD_W-1:0] FIRST_SPARE_CMD = CMD_W'(CMD_LOAD) + 1'b1;

   typedef enum int {
      SET_RESET,
      SET_ZEROS,
      SET_ONES,
      SET_RANDOM,
      SET_DIRECTED
   } reg_set_type;

   logic                 clock;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_stall;
   logic [CMD_W-1:0]     req_cmd        = '0;
   logic [SEL_W-1:0]     req_row_sel    = '0;
   logic [3:0]           req_load_value = '0;
   logic                 rsp_valid;
   logic                 rsp_stall      = 1'b0;
   logic [GATE_W-1:0]    rsp_gates;
   logic [GATE_W-1:0]    rsp_fired;
   logic                 csr_wr_en      = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index      = '0;
   logic [CSR_W-1:0]     csr_wdata      = '0;

   int   mismatches;
   int   words_pending;
   int   gap_pct   = 0;
   int   stall_pct = 0;
   logic hold_off  = 1'b0;

   cascaded_countdown_trigger_sequencer_unit uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_row_sel    (req_row_sel),
      .req_load_value (req_load_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_gates      (rsp_gates),
      .rsp_fired      (rsp_fired),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   ccts_gate_monitor monitor (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_row_sel    (req_row_sel),
      .req_load_value (req_load_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_gates      (rsp_gates),
      .rsp_fired      (rsp_fired),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatches     (mismatches),
      .words_pending  (words_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard limit, far beyond the slowest correct run.
   initial begin
      #10_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Receiver: stall at the phase's rate; when asked, hold off for a long
   // stretch so that the output register and the block behind it fill up.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_off = 1'b0;
         end
         rsp_stall = ($urandom_range(0, 99) < stall_pct);
      end
   end

   // Offer one word, idling first at the phase's rate, and hold it until it
   // is taken. Valid stays high on return so back-to-back words need no gap.
   task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [SEL_W-1:0] sel,
                           input logic [3:0] val);
      @(negedge clock);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid      = 1'b1;
      req_cmd        = cmd;
      req_row_sel    = sel;
      req_load_value = val;
      do begin
         @(posedge clock);
      end while (req_stall);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_W-1:0] data);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // Drop valid and wait until every predicted word has come back.
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (words_pending != 0) @(negedge clock);
   endtask

   task automatic program_regs(input reg_set_type kind);
      logic [CSR_W-1:0] v [8];
      case (kind)
         SET_RESET: begin
            v[CSR_SPEED]  = CSR_W'(SPEED_RESET);
            v[CSR_MIN]    = CSR_W'(MIN_RESET);
            v[CSR_MAX]    = CSR_W'(MAX_RESET);
            v[CSR_RULE]   = CSR_W'(RULE_RESET);
            v[CSR_DEST]   = CSR_W'(DEST_RESET);
            v[CSR_SYNC]   = SYNC_RESET;
            v[CSR_TRIG]   = TRIG_RESET;
            v[CSR_TOGGLE] = TOGGLE_RESET;
         end
         SET_ZEROS: for (int i = 0; i < 8; i++) v[i] = '0;
         SET_ONES:  for (int i = 0; i < 8; i++) v[i] = '1;
         SET_DIRECTED: begin
            // Row 1 runs at half rate, row 7 at the slowest rate.
            v[CSR_SPEED]  = 64'h7000_0010;
            // Row 4 has max below min, so its random rule has a span of one.
            v[CSR_MIN]    = 64'h0012_4032;
            v[CSR_MAX]    = 64'hFFC1_5F94;
            // Rows 0..7: inc, dec, max, min, rnd, pole, stop, stop.
            v[CSR_RULE]   = 64'hFF_58D1;
            // Each row on itself, except row 6 which stops row 2.
            v[CSR_DEST]   = 64'hEA_C688;
            // Row 5 resyncs row 6 as well as itself.
            v[CSR_SYNC]   = 64'h8040_6010_0804_0201;
            v[CSR_TRIG]   = 64'h8040_2010_0804_0201;
            // Row 3 toggles gates 0..2 (its own gate is pulsed); row 7 toggles gates 0..6 (its own is pulsed).
            v[CSR_TOGGLE] = 64'hFF00_0000_0F00_0000;
         end
         default: begin
            v[CSR_SPEED] = '0;
            for (int r = 0; r < ROWS; r++)
               v[CSR_SPEED][NIBBLE*r +: NIBBLE] = ($urandom_range(0, 3) == 0) ?
                  NIBBLE'($urandom_range(0, 15)) : NIBBLE'($urandom_range(0, 1));
            v[CSR_MIN]    = CSR_W'($urandom);
            v[CSR_MAX]    = CSR_W'($urandom);
            v[CSR_RULE]   = CSR_W'($urandom);
            v[CSR_DEST]   = CSR_W'($urandom);
            v[CSR_SYNC]   = {$urandom, $urandom};
            // Mostly keep every row restarting itself so the cascade stays alive.
            if ($urandom_range(0, 3) != 0) v[CSR_SYNC] |= SYNC_RESET;
            v[CSR_TRIG]   = {$urandom, $urandom};
            v[CSR_TOGGLE] = {$urandom, $urandom};
         end
      endcase
      for (int i = 0; i < 8; i++) write_reg(csr_index_type'(i), v[i]);
   endtask

   // Mostly rising and falling ticks, with loads, resets and stops between,
   // and a few spare command codes as noise.
   task automatic send_random_word();
      int               pick;
      logic [SEL_W-1:0] sel;
      logic [3:0]       val;
      pick = $urandom_range(0, 99);
      sel  = ($urandom_range(0, 2) == 0) ? '0 : SEL_W'($urandom_range(0, 15));
      val  = 4'($urandom_range(0, 15));
      if (pick < 42)
         send_cmd(CMD_RISE, sel, val);
      else if (pick < 74)
         send_cmd(CMD_FALL, sel, val);
      else if (pick < 83)
         send_cmd(CMD_LOAD, ($urandom_range(0, 3) == 0) ? SEL_W'($urandom_range(0, 15))
                                                        : SEL_W'($urandom_range(0, ROWS - 1)),
                  val);
      else if (pick < 90)
         send_cmd(CMD_RESET, sel, val);
      else if (pick < 96)
         send_cmd(CMD_STOP, sel, val);
      else
         send_cmd(FIRST_SPARE_CMD + CMD_W'($urandom_range(0, 2)), sel, val);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: extremes of each field, every command, the rules.
      program_regs(SET_DIRECTED);
      send_cmd(CMD_LOAD, 4'd0, 4'd0);
      send_cmd(CMD_LOAD, 4'd1, 4'd0);    // decrement from zero lands on max
      send_cmd(CMD_LOAD, 4'd2, 4'd15);
      send_cmd(CMD_LOAD, 4'd7, 4'd0);    // row 7 stops itself when it fires
      send_cmd(CMD_LOAD, 4'd15, 4'd15);  // row out of range: ignored
      send_cmd(CMD_RISE, 4'd0, 4'd0);
      send_cmd(CMD_FALL, 4'd0, 4'd0);
      send_cmd(CMD_RISE, 4'd15, 4'd15);
      send_cmd(CMD_RESET, 4'd9, 4'd0);   // selector past the last row
      send_cmd(CMD_RESET, 4'd0, 4'd0);
      send_cmd(CMD_STOP, 4'd8, 4'd0);
      send_cmd(CMD_STOP, 4'd15, 4'd15);
      send_cmd(FIRST_SPARE_CMD, 4'd15, 4'd15);
      send_cmd(FIRST_SPARE_CMD + 3'd1, 4'd0, 4'd0);
      send_cmd(FIRST_SPARE_CMD + 3'd2, 4'd15, 4'd15);
      send_cmd(CMD_LOAD, 4'd3, 4'd0);
      send_cmd(CMD_LOAD, 4'd4, 4'd0);    // random rule with a span of one
      send_cmd(CMD_LOAD, 4'd5, 4'd0);    // pole, resyncing row 6 too
      send_cmd(CMD_LOAD, 4'd6, 4'd0);    // stop aimed at row 2
      send_cmd(CMD_RISE, 4'd0, 4'd0);
      send_cmd(CMD_FALL, 4'd0, 4'd0);
      send_cmd(CMD_RISE, 4'd0, 4'd0);
      send_cmd(CMD_STOP, 4'd0, 4'd0);
      send_cmd(CMD_RISE, 4'd0, 4'd0);
      send_cmd(CMD_FALL, 4'd0, 4'd0);

      // Random part: two register settings per idling phase.
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         drain();
         case (seg / 2)
            0:       begin gap_pct = 0;  stall_pct = 0;  end
            1:       begin gap_pct = 63; stall_pct = 0;  end
            2:       begin gap_pct = 0;  stall_pct = 63; end
            default: begin gap_pct = 28; stall_pct = 28; end
         endcase
         case (seg)
            0:       program_regs(SET_RESET);
            1:       program_regs(SET_ZEROS);
            5:       program_regs(SET_ONES);
            default: program_regs(SET_RANDOM);
         endcase
         // Back up the block once while the sender keeps offering words.
         if (seg == 0) hold_off = 1'b1;
         repeat (WORDS_PER_SEGMENT) send_random_word();
      end

      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
